>>> rtl/block_mean_downsample_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block mean downsampler
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MEAN_DOWNSAMPLE_ASSERT_SVH
`define BLOCK_MEAN_DOWNSAMPLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define BMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bmd_pkg.sv
// ----------------------------------------------------------------------------
// bmd_pkg
// Types, constants and helper functions of the block mean downsampler.
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int MAX_SIZE    = 512;
    localparam int MAX_BLOCK   = 16;
    localparam int VALUE_BITS  = 24;
    localparam int SUM_BITS    = 32;
    localparam int CNT_BITS    = 9;
    localparam int ADDR_BITS   = 9;
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_BITS  = 15;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_SIZE    = 2'd0;
    localparam logic [1:0] REG_BLOCK_DIM     = 2'd1;
    localparam logic [1:0] REG_MISSING_VALUE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } bmd_state_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]        count;
        logic signed [SUM_BITS-1:0] sum;
    } bmd_entry_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        bmd_entry_t           data;
    } bmd_ram_wr_t;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] dividend;
        logic [CNT_BITS-1:0]        divisor;
    } bmd_div_req_t;

    typedef struct packed {
        logic                         done;
        logic signed [VALUE_BITS-1:0] quotient;
    } bmd_div_rsp_t;

    // Rounded-up reciprocal 2^14 / b; exact floor division for values below 1024/b.
    function automatic logic [RECIP_BITS-1:0] recip(input logic [4:0] b);
        logic [RECIP_BITS-1:0] r;
        case (b)
            5'd1:    r = 15'd16384;
            5'd2:    r = 15'd8192;
            5'd3:    r = 15'd5462;
            5'd4:    r = 15'd4096;
            5'd5:    r = 15'd3277;
            5'd6:    r = 15'd2731;
            5'd7:    r = 15'd2341;
            5'd8:    r = 15'd2048;
            5'd9:    r = 15'd1821;
            5'd10:   r = 15'd1639;
            5'd11:   r = 15'd1490;
            5'd12:   r = 15'd1366;
            5'd13:   r = 15'd1261;
            5'd14:   r = 15'd1171;
            5'd15:   r = 15'd1093;
            5'd16:   r = 15'd1024;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/bmd_acc_ram.sv
// ----------------------------------------------------------------------------
// bmd_acc_ram
// Per tile column accumulator memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmd_acc_ram (
    input  logic                          clk,
    input  bmd_pkg::bmd_ram_wr_t          wr,
    input  logic                          rd_en,
    input  logic [bmd_pkg::ADDR_BITS-1:0] rd_addr,
    output bmd_pkg::bmd_entry_t           rd_data
);
    import bmd_pkg::*;

    bmd_entry_t mem [MAX_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bmd_div.sv
// ----------------------------------------------------------------------------
// bmd_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmd_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmd_pkg::bmd_div_req_t req,
    output bmd_pkg::bmd_div_rsp_t rsp
);
    import bmd_pkg::*;

    logic                  busy_reg;
    logic [4:0]            step_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [SUM_BITS-1:0]   dvd_reg;
    logic [CNT_BITS-1:0]   rem_reg;
    logic [CNT_BITS-1:0]   dsr_reg;
    logic [CNT_BITS:0]     rem_shift;
    logic                  ge;
    logic [CNT_BITS-1:0]   rem_next;
    logic [SUM_BITS-1:0]   mag;
    logic [SUM_BITS-1:0]   quot_signed;

    assign mag       = req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
                                                : SUM_BITS'(req.dividend);
    assign rem_shift = {rem_reg, dvd_reg[SUM_BITS-1]};
    assign ge        = rem_shift >= {1'b0, dsr_reg};
    assign rem_next  = ge ? CNT_BITS'(rem_shift - {1'b0, dsr_reg})
                          : CNT_BITS'(rem_shift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 5'd31;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= mag;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            neg_reg <= req.dividend[SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_BITS-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    // The mean always fits in the pixel range, so the low bits carry it.
    assign quot_signed  = neg_reg ? SUM_BITS'(-dvd_reg) : dvd_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_signed[VALUE_BITS-1:0];

endmodule

>>> rtl/block_mean_downsample.sv
// ----------------------------------------------------------------------------
// block_mean_downsample
// Block mean downsampler with missing-value mask over a square raster image.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream, one signed Q15.8 value per transaction, in
// raster order. Each tile of block_dim x block_dim pixels yields one result on
// the m_ stream when its last pixel arrives: the mean of its valid pixels
// (truncated toward zero), or the missing sentinel with tuser set. tlast marks
// the final tile of the reduced image. Registers are written on the cfg_
// channel, which is always ready; a write holds off pixels while the reduced
// size is recomputed.
// A pixel inside the whole-tile area goes through ST_QUOT, the accumulator
// memory read in ST_READ and the update and write back in ST_UPDATE; a pixel
// outside it leaves after ST_READ. A pixel that closes a tile with valid pixels
// then waits in ST_DIVIDE for the serial divider, and ST_EMIT loads the
// output register. The memory read-modify-write handles one pixel at a time.
// After reset the block clears its 512-entry accumulator memory, one entry a
// cycle, before it accepts the first pixel. A result waits in the output
// register while m_tready is low; the next pixel is still accepted and
// processed, and only a second finished result waits for the first.
// ----------------------------------------------------------------------------
module block_mean_downsample (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] pixel_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [23:0] mean_value, [32:24] out_row,
                                   // [41:33] out_col, [51:42] reduced_size, zero pad
    output logic        m_tlast,   // frame_last
    output logic [0:0]  m_tuser,   // [0] all_missing
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import bmd_pkg::*;

    bmd_state_t state_reg, state_next;

    logic [9:0]                    image_size_reg;
    logic [4:0]                    block_dim_reg;
    logic signed [VALUE_BITS-1:0]  missing_reg;
    logic [1:0]                    settle_reg;
    logic [9:0]                    reduced_reg;
    logic [9:0]                    adj_reg;
    logic [ADDR_BITS-1:0]          clr_addr_reg;

    logic [ADDR_BITS-1:0]          row_pos_reg, col_pos_reg;
    logic [ADDR_BITS-1:0]          row_reg, col_reg;
    logic signed [VALUE_BITS-1:0]  pixel_reg;
    logic [ADDR_BITS-1:0]          tile_col_reg, tile_row_reg;
    logic                          first_reg, last_reg, none_reg;

    logic                          out_valid_reg;
    logic signed [VALUE_BITS-1:0]  mean_reg;
    logic                          all_missing_reg;
    logic [ADDR_BITS-1:0]          out_row_reg, out_col_reg;
    logic [9:0]                    out_reduced_reg;
    logic                          frame_last_reg;

    logic [9:0]                    n_eff;
    logic [4:0]                    b_eff;
    logic [RECIP_BITS-1:0]         recip_b;
    logic [24:0]                   red_prod;
    logic [14:0]                   adj_prod;
    logic [23:0]                   col_prod, row_prod;
    logic [13:0]                   col_base, row_base;
    logic [ADDR_BITS-1:0]          col_in_tile, row_in_tile, b_last;
    logic                          in_area;
    logic [ADDR_BITS:0]            col_inc, row_inc;

    logic                          in_accept;
    logic                          load_out;
    bmd_ram_wr_t                   ram_wr;
    logic                          ram_rd_en;
    bmd_entry_t                    ram_rd_data;
    bmd_entry_t                    upd_entry;
    logic                          pixel_ok;
    bmd_div_req_t                  div_req;
    bmd_div_rsp_t                  div_rsp;

    bmd_acc_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (tile_col_reg),
        .rd_data (ram_rd_data)
    );

    bmd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Effective sizes and derived geometry.
    assign n_eff = (image_size_reg == 10'd0) ? 10'd1 :
                   (image_size_reg > 10'(MAX_SIZE)) ? 10'(MAX_SIZE) : image_size_reg;
    assign b_eff = (block_dim_reg == 5'd0) ? 5'd1 :
                   (block_dim_reg > 5'(MAX_BLOCK)) ? 5'(MAX_BLOCK) : block_dim_reg;
    assign recip_b  = recip(b_eff);
    assign red_prod = 25'(n_eff) * 25'(recip_b);
    assign adj_prod = 15'(reduced_reg) * 15'(b_eff);

    // Tile coordinates by reciprocal multiplication.
    assign col_prod = 24'(col_reg) * 24'(recip_b);
    assign row_prod = 24'(row_reg) * 24'(recip_b);
    assign col_base = 14'(tile_col_reg) * 14'(b_eff);
    assign row_base = 14'(tile_row_reg) * 14'(b_eff);
    assign col_in_tile = col_reg - col_base[ADDR_BITS-1:0];
    assign row_in_tile = row_reg - row_base[ADDR_BITS-1:0];
    assign b_last  = ADDR_BITS'(b_eff) - 9'd1;
    assign in_area = ({1'b0, row_reg} < adj_reg) && ({1'b0, col_reg} < adj_reg);

    assign col_inc = {1'b0, col_pos_reg} + 10'd1;
    assign row_inc = {1'b0, row_pos_reg} + 10'd1;

    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Accumulator update for the pixel in flight.
    assign pixel_ok = (pixel_reg != missing_reg);
    always_comb
    begin
        upd_entry = first_reg ? '0 : ram_rd_data;
        if (pixel_ok)
        begin
            upd_entry.sum   = upd_entry.sum + SUM_BITS'(pixel_reg);
            upd_entry.count = upd_entry.count + 9'd1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_BITS'(MAX_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = in_area ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (upd_entry.count == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready         = 1'b0;
        ram_rd_en        = 1'b0;
        ram_wr.en        = 1'b0;
        ram_wr.addr      = tile_col_reg;
        ram_wr.data      = upd_entry;
        div_req.start    = 1'b0;
        div_req.dividend = upd_entry.sum;
        div_req.divisor  = upd_entry.count;
        load_out         = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = clr_addr_reg;
                ram_wr.data = '0;
            end
            ST_IDLE:
            begin
                s_tready = (settle_reg == 2'd0);
            end
            ST_READ:
            begin
                ram_rd_en = in_area;
            end
            ST_UPDATE:
            begin
                ram_wr.en     = 1'b1;
                div_req.start = last_reg && (upd_entry.count != '0);
            end
            ST_EMIT:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            image_size_reg <= 10'd512;
            block_dim_reg  <= 5'd2;
            missing_reg    <= -24'sd8388608;
            settle_reg     <= 2'd0;
            reduced_reg    <= 10'd256;
            adj_reg        <= 10'd512;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            reduced_reg <= red_prod[RECIP_SHIFT+9:RECIP_SHIFT];
            adj_reg     <= adj_prod[9:0];
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 9'd1;
            end
            if (cfg_valid && cfg_ready)
            begin
                settle_reg <= 2'd2;
                case (cfg_index)
                    REG_IMAGE_SIZE:    image_size_reg <= cfg_data[9:0];
                    REG_BLOCK_DIM:     block_dim_reg  <= cfg_data[4:0];
                    REG_MISSING_VALUE: missing_reg    <= cfg_data;
                    default: ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
            if (in_accept)
            begin
                if (col_inc >= n_eff)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= (row_inc >= n_eff) ? '0 : row_inc[ADDR_BITS-1:0];
                end
                else
                begin
                    col_pos_reg <= col_inc[ADDR_BITS-1:0];
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pixel_reg <= s_tdata;
            row_reg   <= row_pos_reg;
            col_reg   <= col_pos_reg;
        end
        if (state_reg == ST_QUOT)
        begin
            tile_col_reg <= col_prod[RECIP_SHIFT+8:RECIP_SHIFT];
            tile_row_reg <= row_prod[RECIP_SHIFT+8:RECIP_SHIFT];
        end
        if (state_reg == ST_READ)
        begin
            first_reg <= (col_in_tile == '0) && (row_in_tile == '0);
            last_reg  <= (col_in_tile == b_last) && (row_in_tile == b_last);
        end
        if (state_reg == ST_UPDATE)
        begin
            none_reg <= (upd_entry.count == '0);
        end
        if (load_out)
        begin
            mean_reg        <= none_reg ? missing_reg : div_rsp.quotient;
            all_missing_reg <= none_reg;
            out_row_reg     <= tile_row_reg;
            out_col_reg     <= tile_col_reg;
            out_reduced_reg <= reduced_reg;
            frame_last_reg  <= ({1'b0, tile_row_reg} == reduced_reg - 10'd1)
                            && ({1'b0, tile_col_reg} == reduced_reg - 10'd1);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0, out_reduced_reg, out_col_reg, out_row_reg, mean_reg};
    assign m_tlast    = frame_last_reg;
    assign m_tuser[0] = all_missing_reg;

endmodule

>>> rtl/bmd_checker.sv
// ----------------------------------------------------------------------------
// bmd_checker
// Port-level checks of the block mean downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_mean_downsample_assert.svh"

module bmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result keeps its contents.
    `BMD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Pixels are taken one at a time: no transaction in the cycle after one.
    `BMD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // Tile coordinates lie inside the reduced image.
    `BMD_ASSERT_NOW(a_coord_range, clk, rst_n, m_tvalid, (m_tdata[32:24] < m_tdata[51:42]) && (m_tdata[41:33] < m_tdata[51:42]))

    // The frame end sits on the bottom-right tile.
    `BMD_ASSERT_NOW(a_last_corner, clk, rst_n, m_tvalid && m_tlast, ({1'b0, m_tdata[32:24]} == m_tdata[51:42] - 10'd1) && ({1'b0, m_tdata[41:33]} == m_tdata[51:42] - 10'd1))

endmodule

bind block_mean_downsample bmd_checker u_bmd_checker (.*);
